// ===== sv/ufmst_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ufmst_pkg;

	// Fixed field widths of the edge and configuration interfaces.
	localparam int VTX_W  = 7;
	localparam int VCNT_W = 8;

	// Reset value of the vertex count register.
	localparam logic [VCNT_W-1:0] VCNT_RESET = 8'd128;

	// Input mode codes.
	localparam logic MODE_CLEAR = 1'b0;
	localparam logic MODE_EDGE  = 1'b1;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_FIND,
		ST_HALVE,
		ST_SIZE,
		ST_LINK,
		ST_FINISH
	} state_t;

endpackage

`default_nettype wire

// ===== sv/union_find_mst_edge_filter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Sequence: an edge is taken in the idle state, and the roots of its source and then of its destination
// are found in the find and halve states with path halving over the parent memory loop; if they differ,
// the set sizes are read in the size state and the sets are linked in the link state. An illegal edge goes
// to the finish state without finds, a clear runs a sweep. Only one item is in work at a time.
// Reset: asynchronous, active low; afterwards a sweep over all MAX_VERTICES entries initializes
// the memories while no item is taken. Configuration writes are taken at any time.

module union_find_mst_edge_filter
	import ufmst_pkg::*;
#(
	parameter int MAX_VERTICES = 128,
	parameter int WEIGHT_BITS  = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,
	// Configuration.
	input  wire                          cfg_we,
	input  wire [VCNT_W-1:0]             cfg_wdata,
	// Input channel.
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire                          mode,
	input  wire [VTX_W-1:0]              edge_src,
	input  wire [VTX_W-1:0]              edge_dst,
	input  wire signed [WEIGHT_BITS-1:0] edge_weight,
	// Output channel.
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic                         accepted,
	output logic [VTX_W-1:0]             out_low_vertex,
	output logic [VTX_W-1:0]             out_high_vertex,
	output logic signed [WEIGHT_BITS-1:0] out_weight,
	output logic [VTX_W-1:0]             accepted_total,
	output logic                         tree_done
);

	localparam int IDX_W  = (MAX_VERTICES > 2) ? $clog2(MAX_VERTICES) : 1;
	localparam int SIZE_W = $clog2(MAX_VERTICES + 1);
	localparam int N_W    = (SIZE_W > VCNT_W) ? SIZE_W : VCNT_W;

	// Disjoint-set memories.
	logic [IDX_W-1:0]  parent_mem [MAX_VERTICES];
	logic [SIZE_W-1:0] size_mem   [MAX_VERTICES];

	logic              par_we;
	logic [IDX_W-1:0]  par_waddr;
	logic [IDX_W-1:0]  par_wdata;
	logic [IDX_W-1:0]  par_raddr;
	logic [IDX_W-1:0]  par_rdata_q;
	logic              size_we;
	logic [IDX_W-1:0]  size_waddr;
	logic [SIZE_W-1:0] size_wdata;
	logic [IDX_W-1:0]  size_raddr;
	logic [SIZE_W-1:0] size_rdata_q;

	// Control and datapath registers.
	state_t                  state_q, state_d;
	logic [VCNT_W-1:0]       vcount_q;
	logic [IDX_W-1:0]        sw_q;
	logic                    clr_q;
	logic [N_W-1:0]          cnt_q;
	logic                    mode_q;
	logic [VTX_W-1:0]        src_q;
	logic [VTX_W-1:0]        dst_q;
	logic [WEIGHT_BITS-1:0]  weight_q;
	logic                    acc_q;
	logic                    sel_q;
	logic [IDX_W-1:0]        v_q;
	logic [IDX_W-1:0]        rs_q;
	logic [IDX_W-1:0]        rd_q;
	logic [SIZE_W-1:0]       size_a_q;
	logic                    out_valid_q;
	logic                    accepted_q;
	logic [VTX_W-1:0]        low_q;
	logic [VTX_W-1:0]        high_q;
	logic [WEIGHT_BITS-1:0]  out_weight_q;
	logic [VTX_W-1:0]        total_q;
	logic                    done_q;

	// Effective vertex count: zero is taken as one, larger counts are cut to the range that the memory holds.
	logic [N_W-1:0] n_eff;
	always_comb begin
		if (vcount_q == '0) begin
			n_eff = N_W'(1);
		end else if (N_W'(vcount_q) > N_W'(MAX_VERTICES)) begin
			n_eff = N_W'(MAX_VERTICES);
		end else begin
			n_eff = N_W'(vcount_q);
		end
	end

	logic [N_W:0] cnt_inc;
	logic         edge_legal;
	logic         out_free;
	logic         sweep_last;
	logic [SIZE_W-1:0] size_sum;
	logic         link_rs_under;
	assign cnt_inc       = {1'b0, cnt_q} + {{N_W{1'b0}}, 1'b1};
	assign edge_legal    = (N_W'(edge_src) < n_eff) && (N_W'(edge_dst) < n_eff)
	                       && (cnt_inc < {1'b0, n_eff});
	assign out_free      = !out_valid_q || out_ready;
	assign sweep_last    = (sw_q == IDX_W'(MAX_VERTICES - 1));
	assign size_sum      = size_a_q + size_rdata_q;
	assign link_rs_under = (size_a_q < size_rdata_q);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory port control.
	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		par_we     = 1'b0;
		par_waddr  = v_q;
		par_wdata  = par_rdata_q;
		par_raddr  = par_rdata_q;
		size_we    = 1'b0;
		size_waddr = rs_q;
		size_wdata = size_sum;
		size_raddr = rs_q;
		case (state_q)
			ST_SWEEP: begin
				par_we     = 1'b1;
				par_waddr  = sw_q;
				par_wdata  = sw_q;
				size_we    = 1'b1;
				size_waddr = sw_q;
				size_wdata = SIZE_W'(1);
				if (sweep_last) begin
					state_d = clr_q ? ST_FINISH : ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready  = 1'b1;
				par_raddr = IDX_W'(edge_src);
				if (in_valid) begin
					if (mode == MODE_CLEAR) begin
						state_d = ST_SWEEP;
					end else if (edge_legal) begin
						state_d = ST_FIND;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_FIND: begin
				if (par_rdata_q == v_q) begin
					if (!sel_q) begin
						par_raddr = IDX_W'(dst_q);
					end else if (rs_q == v_q) begin
						state_d = ST_FINISH;
					end else begin
						size_raddr = rs_q;
						state_d    = ST_SIZE;
					end
				end else begin
					// Fetch the grandparent for one halving step.
					par_raddr = par_rdata_q;
					state_d   = ST_HALVE;
				end
			end
			ST_HALVE: begin
				// Link the vertex to its grandparent and move on to it.
				par_we    = 1'b1;
				par_waddr = v_q;
				par_wdata = par_rdata_q;
				par_raddr = par_rdata_q;
				state_d   = ST_FIND;
			end
			ST_SIZE: begin
				size_raddr = rd_q;
				state_d    = ST_LINK;
			end
			ST_LINK: begin
				par_we  = 1'b1;
				size_we = 1'b1;
				if (link_rs_under) begin
					par_waddr  = rs_q;
					par_wdata  = rd_q;
					size_waddr = rd_q;
				end else begin
					par_waddr  = rd_q;
					par_wdata  = rs_q;
					size_waddr = rs_q;
				end
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_SWEEP;
			end
		endcase
	end

	// Parent link memory.
	always_ff @(posedge clk) begin
		if (par_we) begin
			parent_mem[par_waddr] <= par_wdata;
		end
		par_rdata_q <= parent_mem[par_raddr];
	end

	// Set size memory.
	always_ff @(posedge clk) begin
		if (size_we) begin
			size_mem[size_waddr] <= size_wdata;
		end
		size_rdata_q <= size_mem[size_raddr];
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q    <= VCNT_RESET;
			sw_q        <= '0;
			clr_q       <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				vcount_q <= cfg_wdata;
			end
			if (state_q == ST_SWEEP) begin
				sw_q <= sweep_last ? '0 : sw_q + IDX_W'(1);
			end
			if (state_q == ST_IDLE && in_valid && mode == MODE_CLEAR) begin
				clr_q <= 1'b1;
				cnt_q <= '0;
			end
			if (state_q == ST_LINK) begin
				cnt_q <= cnt_inc[N_W-1:0];
			end
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item and find registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				mode_q   <= mode;
				src_q    <= edge_src;
				dst_q    <= edge_dst;
				weight_q <= edge_weight;
				acc_q    <= 1'b0;
				sel_q    <= 1'b0;
				v_q      <= IDX_W'(edge_src);
			end
			ST_FIND: begin
				if (par_rdata_q == v_q) begin
					if (!sel_q) begin
						rs_q  <= v_q;
						sel_q <= 1'b1;
						v_q   <= IDX_W'(dst_q);
					end else begin
						rd_q <= v_q;
					end
				end
			end
			ST_HALVE: begin
				v_q <= par_rdata_q;
			end
			ST_SIZE: begin
				size_a_q <= size_rdata_q;
			end
			ST_LINK: begin
				acc_q <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Result register, loaded when the previous result has been transferred.
	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			if (mode_q == MODE_CLEAR) begin
				accepted_q   <= 1'b0;
				low_q        <= '0;
				high_q       <= '0;
				out_weight_q <= '0;
				total_q      <= '0;
				done_q       <= (n_eff == N_W'(1));
			end else begin
				accepted_q   <= acc_q;
				low_q        <= (src_q < dst_q) ? src_q : dst_q;
				high_q       <= (src_q < dst_q) ? dst_q : src_q;
				out_weight_q <= weight_q;
				total_q      <= cnt_q[VTX_W-1:0];
				done_q       <= (cnt_inc >= {1'b0, n_eff});
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign accepted        = accepted_q;
	assign out_low_vertex  = low_q;
	assign out_high_vertex = high_q;
	assign out_weight      = out_weight_q;
	assign accepted_total  = total_q;
	assign tree_done       = done_q;

`ifndef ASSERT_OFF
	// A halving step never reads the entry it writes.
	a_halve_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HALVE) |-> (par_waddr != par_raddr))
		else $error("halving step reads the entry it writes");

	// Two sets are only linked when their roots differ.
	a_link_roots_differ: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LINK) |-> (rs_q != rd_q))
		else $error("link of a set to itself");

	// A result appears only after the finish state.
	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result raised outside the finish state");

	// A clear sweep starts at the first entry.
	a_sweep_from_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && state_d == ST_SWEEP) |=> (sw_q == '0))
		else $error("clear sweep does not start at entry zero");
`endif

endmodule

`default_nettype wire
